/* rtl/core/gsg_pkg.sv */
// Shared types, constants and widths for the gray Sobel gradient block.
package gsg_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int PIX_W      = 8;
    localparam int CFG_W      = 13;
    localparam int COORD_W    = 12;
    localparam int GRAD_W     = 9;
    localparam int LINE_W     = 2 * PIX_W;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET = 13'd640;
    localparam int               MIN_WIDTH         = 3;

    // Luma weights for (38r + 75g + 15b) >> 7.
    localparam logic [15:0] GRAY_R_COEF = 16'd38;
    localparam logic [15:0] GRAY_G_COEF = 16'd75;
    localparam logic [15:0] GRAY_B_COEF = 16'd15;
    localparam int          GRAY_SHIFT  = 7;

    localparam int OUT_FIFO_DEPTH = 3;

    // Control that travels with a pixel from the accept stage to the kernel stage.
    typedef struct packed {
        logic valid;
        logic emit;
        logic fwd;
    } t_s1_ctl;

    // One gradient result; first field in the highest bits when packed.
    typedef struct packed {
        logic        [COORD_W-1:0] center_row;
        logic        [COORD_W-1:0] center_col;
        logic signed [GRAD_W-1:0]  grad_vertical;
        logic signed [GRAD_W-1:0]  grad_horizontal;
    } t_result;

endpackage

/* rtl/core/gsg_line_mem.sv */
// Line memory holding the gray values of the two previous rows per column.
module gsg_line_mem
    import gsg_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEF_MAX_WIDTH)
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [LINE_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [LINE_W-1:0] i_wr_data
);

    logic [LINE_W-1:0] r_mem [DEPTH];
    logic [LINE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/gsg_front.sv */
// Accept stage: position counters, width register, gray conversion and line memory read.
module gsg_front
    import gsg_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int CW         = $clog2(DEF_MAX_WIDTH),
    parameter int RW         = $clog2(DEF_MAX_HEIGHT)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_wr_data,
    input  logic              i_accept,
    input  logic [PIX_W-1:0]  i_blue,
    input  logic [PIX_W-1:0]  i_green,
    input  logic [PIX_W-1:0]  i_red,
    input  logic              i_sof,
    input  logic              i_wr_en,
    input  logic [CW-1:0]     i_wr_addr,
    input  logic [LINE_W-1:0] i_wr_data,
    output logic [CW-1:0]     o_rd_addr,
    output t_s1_ctl           o_ctl,
    output logic [CW-1:0]     o_col,
    output logic [RW-1:0]     o_row,
    output logic [PIX_W-1:0]  o_gray,
    output logic [LINE_W-1:0] o_fwd_data
);

    localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;

    logic [CFG_W-1:0]  r_image_width;
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    t_s1_ctl           r_ctl;
    logic [CW-1:0]     r_s1_col;
    logic [RW-1:0]     r_s1_row;
    logic [PIX_W-1:0]  r_gray;
    logic [LINE_W-1:0] r_fwd_data;

    logic [WW-1:0]     w_cfg_ext;
    logic [WW-1:0]     w_eff;
    logic [CW-1:0]     w_col_base;
    logic [CW-1:0]     w_col_cur;
    logic [RW-1:0]     w_row_cur;
    logic [WW-1:0]     w_col_inc;
    logic [CW-1:0]     n_col;
    logic [RW-1:0]     n_row;
    logic [15:0]       w_sum;

    always_comb begin
        w_cfg_ext = WW'(r_image_width);
        if (w_cfg_ext < WW'(MIN_WIDTH)) begin
            w_eff = WW'(MIN_WIDTH);
        end else if (w_cfg_ext > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_cfg_ext;
        end

        w_col_base = i_sof ? '0 : r_col;
        w_col_cur  = (WW'(w_col_base) >= w_eff) ? '0 : w_col_base;
        w_row_cur  = i_sof ? '0 : r_row;

        w_col_inc = WW'(w_col_cur) + WW'(1);
        if (w_col_inc >= w_eff) begin
            n_col = '0;
            n_row = (w_row_cur < RW'(MAX_HEIGHT - 1)) ? w_row_cur + RW'(1) : w_row_cur;
        end else begin
            n_col = w_col_inc[CW-1:0];
            n_row = w_row_cur;
        end

        w_sum = GRAY_R_COEF * 16'(i_red) + GRAY_G_COEF * 16'(i_green)
              + GRAY_B_COEF * 16'(i_blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= IMAGE_WIDTH_RESET;
            r_col         <= '0;
            r_row         <= '0;
            r_ctl         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_image_width <= i_cfg_wr_data;
            end
            r_ctl.valid <= i_accept;
            if (i_accept) begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_ctl.emit <= (w_row_cur >= RW'(2)) && (w_col_cur >= CW'(2));
                // The kernel stage writes this column in the same edge as the read.
                r_ctl.fwd  <= i_wr_en && (i_wr_addr == w_col_cur);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_col   <= w_col_cur;
            r_s1_row   <= w_row_cur;
            r_gray     <= w_sum[GRAY_SHIFT +: PIX_W];
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_addr  = w_col_cur;
    assign o_ctl      = r_ctl;
    assign o_col      = r_s1_col;
    assign o_row      = r_s1_row;
    assign o_gray     = r_gray;
    assign o_fwd_data = r_fwd_data;

endmodule

/* rtl/core/gsg_kernel.sv */
// Kernel stage: 3x3 window, Sobel sums, line memory write-back.
module gsg_kernel
    import gsg_pkg::*;
#(
    parameter int CW = $clog2(DEF_MAX_WIDTH),
    parameter int RW = $clog2(DEF_MAX_HEIGHT)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_s1_ctl           i_ctl,
    input  logic [CW-1:0]     i_col,
    input  logic [RW-1:0]     i_row,
    input  logic [PIX_W-1:0]  i_gray,
    input  logic [LINE_W-1:0] i_rd_data,
    input  logic [LINE_W-1:0] i_fwd_data,
    output logic              o_wr_en,
    output logic [CW-1:0]     o_wr_addr,
    output logic [LINE_W-1:0] o_wr_data,
    output logic              o_push,
    output t_result           o_result
);

    logic [PIX_W-1:0] r_win [6];

    logic [LINE_W-1:0]  w_line;
    logic [PIX_W-1:0]   w_up;
    logic [PIX_W-1:0]   w_mid;
    logic signed [10:0] a0, a1, a2, b0, b2, c0, c1, c2;
    logic signed [10:0] w_gx;
    logic signed [10:0] w_gy;
    logic signed [10:0] w_gx_q;
    logic signed [10:0] w_gy_q;

    always_comb begin
        w_line = i_ctl.fwd ? i_fwd_data : i_rd_data;
        w_up   = w_line[LINE_W-1 -: PIX_W];
        w_mid  = w_line[PIX_W-1:0];

        a0 = $signed({3'b000, r_win[0]});
        a1 = $signed({3'b000, r_win[1]});
        a2 = $signed({3'b000, r_win[2]});
        b0 = $signed({3'b000, r_win[3]});
        b2 = $signed({3'b000, r_win[5]});
        c0 = $signed({3'b000, w_up});
        c1 = $signed({3'b000, w_mid});
        c2 = $signed({3'b000, i_gray});

        w_gx = (c0 - a0) + ((c1 - a1) <<< 1) + (c2 - a2);
        w_gy = (a2 + (b2 <<< 1) + c2) - (a0 + (b0 <<< 1) + c0);

        // Divide by four, rounding toward zero.
        w_gx_q = (w_gx < 0) ? ((w_gx + 11'sd3) >>> 2) : (w_gx >>> 2);
        w_gy_q = (w_gy < 0) ? ((w_gy + 11'sd3) >>> 2) : (w_gy >>> 2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_ctl.valid) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= w_up;
            r_win[4] <= w_mid;
            r_win[5] <= i_gray;
        end
    end

    assign o_wr_en   = i_ctl.valid;
    assign o_wr_addr = i_col;
    assign o_wr_data = {w_mid, i_gray};

    assign o_push                   = i_ctl.valid && i_ctl.emit;
    assign o_result.grad_horizontal = GRAD_W'(w_gx_q);
    assign o_result.grad_vertical   = GRAD_W'(w_gy_q);
    assign o_result.center_col      = COORD_W'(32'(i_col) - 32'd1);
    assign o_result.center_row      = COORD_W'(32'(i_row) - 32'd1);

endmodule

/* rtl/core/gsg_out_fifo.sv */
// Small output queue that decouples the kernel stage from the result stream.
module gsg_out_fifo
    import gsg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    input  logic    i_pop,
    output logic    o_valid,
    output t_result o_result,
    output logic [1:0] o_count
);

    t_result    r_mem [OUT_FIFO_DEPTH];
    logic [1:0] r_wptr;
    logic [1:0] r_rptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign w_pop = i_pop && (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == 2'(OUT_FIFO_DEPTH - 1)) ? 2'd0 : r_wptr + 2'd1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == 2'(OUT_FIFO_DEPTH - 1)) ? 2'd0 : r_rptr + 2'd1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_result;
        end
    end

    assign o_valid  = (r_count != 2'd0);
    assign o_result = r_mem[r_rptr];
    assign o_count  = r_count;

endmodule

/* rtl/core/gray_sobel_gradient.sv */
// A result leaves on m_axis through the accept-stage registers and the result queue.
// Throughput: one pixel per clock; each pixel does one line memory read and one write-back.
// The pixel side stalls only when queued and in-flight results fill the three-entry queue.
// Reset (synchronous, active low) clears the position counters, the window and the
// result queue, and sets image_width to 640; the line memory is not cleared.
module gray_sobel_gradient
    import gsg_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Configuration: image_width, written whenever the enable is high.
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_W-1:0]      i_cfg_wr_data,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // blue [7:0], green [15:8], red [23:16]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // start_of_frame [0]
    input  logic                  s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // grad_horizontal [8:0], grad_vertical [17:9], center_col [29:18],
    // center_row [41:30], zero [47:42]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic              w_accept;
    logic [CW-1:0]     w_rd_addr;
    logic [LINE_W-1:0] w_rd_data;
    logic              w_wr_en;
    logic [CW-1:0]     w_wr_addr;
    logic [LINE_W-1:0] w_wr_data;
    t_s1_ctl           w_ctl;
    logic [CW-1:0]     w_col;
    logic [RW-1:0]     w_row;
    logic [PIX_W-1:0]  w_gray;
    logic [LINE_W-1:0] w_fwd_data;
    logic              w_push;
    t_result           w_result;
    t_result           w_out;
    logic [1:0]        w_fifo_count;
    logic [2:0]        w_in_flight;

    // Every pixel in the kernel stage that carries a result will land in the queue on
    // the next edge, so it is counted against the queue's room before taking another pixel.
    assign w_in_flight   = 3'(w_fifo_count) + 3'(w_ctl.valid && w_ctl.emit);
    assign s_axis_tready = (w_in_flight < 3'(OUT_FIFO_DEPTH));
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    gsg_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (w_accept),
        .i_blue        (s_axis_tdata[7:0]),
        .i_green       (s_axis_tdata[15:8]),
        .i_red         (s_axis_tdata[23:16]),
        .i_sof         (s_axis_tuser),
        .i_wr_en       (w_wr_en),
        .i_wr_addr     (w_wr_addr),
        .i_wr_data     (w_wr_data),
        .o_rd_addr     (w_rd_addr),
        .o_ctl         (w_ctl),
        .o_col         (w_col),
        .o_row         (w_row),
        .o_gray        (w_gray),
        .o_fwd_data    (w_fwd_data)
    );

    // Each entry holds {upper row, middle row} for one column.
    gsg_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    // The kernel stage never stalls: it shifts the window and writes the column back
    // in the cycle after the pixel transaction.
    gsg_kernel #(
        .CW (CW),
        .RW (RW)
    ) u_kernel (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_col      (w_col),
        .i_row      (w_row),
        .i_gray     (w_gray),
        .i_rd_data  (w_rd_data),
        .i_fwd_data (w_fwd_data),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_wr_data  (w_wr_data),
        .o_push     (w_push),
        .o_result   (w_result)
    );

    gsg_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_result),
        .i_pop    (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_result (w_out),
        .o_count  (w_fifo_count)
    );

    assign m_axis_tdata = {6'b000000, w_out};

endmodule

/* rtl/core/gsg_checker.sv */
// Port-level checker for the gray Sobel gradient block, bound to the top level.
module gsg_checker
    import gsg_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // A held result keeps its payload until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Only interior centers are reported, never row or column zero.
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[29:18] != 12'd0) && (m_axis_tdata[41:30] != 12'd0))
        else $error("border coordinate reported");

    // Padding is zero and gradients never reach -256.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[47:42] == 6'd0) && (m_axis_tdata[8:0] != 9'h100)
                          && (m_axis_tdata[17:9] != 9'h100))
        else $error("result out of range");

    // A result that appears on an empty output comes from an earlier pixel transaction.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !$past(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a matching pixel transaction");

endmodule

bind gray_sobel_gradient gsg_checker u_gsg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/gsg_check_pkg.sv */
// Gradient prediction and result matching used by the gray Sobel gradient testbench.
package gsg_check_pkg;
    import gsg_pkg::*;

    localparam int MISMATCH_SHOW_LIMIT = 10;

    class sobel_window;
        bit [PIX_W-1:0] upper_line   [DEF_MAX_WIDTH];
        bit [PIX_W-1:0] middle_line  [DEF_MAX_WIDTH];
        bit             upper_known  [DEF_MAX_WIDTH];
        bit             middle_known [DEF_MAX_WIDTH];
        bit [PIX_W-1:0] window       [6];
        bit             window_known [6];
        int unsigned    col_count;
        int unsigned    row_count;
        bit [CFG_W-1:0] image_width;
        t_result        pending_gradients[$];
        int             errors;
        int             shown;

        function new();
            image_width = IMAGE_WIDTH_RESET;
            foreach (window_known[k]) window_known[k] = 1'b1;
        endfunction

        function void set_width(bit [CFG_W-1:0] value);
            image_width = value;
        endfunction

        function int unsigned active_width();
            if (image_width < MIN_WIDTH) return MIN_WIDTH;
            if (image_width > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
            return image_width;
        endfunction

        function int pending();
            return pending_gradients.size();
        endfunction

        // True when a pixel without a frame start would build a result from
        // line entries that were never written.
        function bit needs_restart();
            int unsigned col;
            col = col_count;
            if (col >= active_width()) col = 0;
            if (row_count < 2 || col < 2) return 1'b0;
            return !(window_known[0] && window_known[1] && window_known[3] &&
                     upper_known[col] && middle_known[col]);
        endfunction

        function void accept_pixel(bit [PIX_W-1:0] blue, bit [PIX_W-1:0] green,
                                   bit [PIX_W-1:0] red, bit sof);
            int unsigned width;
            int unsigned col;
            int unsigned row;
            int          gray;
            int          up;
            int          mid;
            int          a0, a1, a2, b0, b2;
            int          gx;
            int          gy;
            bit          up_ok;
            bit          mid_ok;
            t_result     res;

            width = active_width();
            if (sof) begin
                col_count = 0;
                row_count = 0;
            end
            if (col_count >= width) col_count = 0;
            col = col_count;
            row = row_count;

            gray = (int'(GRAY_R_COEF) * red + int'(GRAY_G_COEF) * green +
                    int'(GRAY_B_COEF) * blue) >> GRAY_SHIFT;
            up     = upper_line[col];
            mid    = middle_line[col];
            up_ok  = upper_known[col];
            mid_ok = middle_known[col];
            upper_line[col]   = middle_line[col];
            upper_known[col]  = mid_ok;
            middle_line[col]  = gray[PIX_W-1:0];
            middle_known[col] = 1'b1;

            a0 = window[0];
            a1 = window[1];
            a2 = window[2];
            b0 = window[3];
            b2 = window[5];

            if (row >= 2 && col >= 2) begin
                gx = (up - a0) + 2 * (mid - a1) + (gray - a2);
                gy = (a2 + 2 * b2 + gray) - (a0 + 2 * b0 + up);
                // Signed division truncates toward zero, as the block does.
                gx = gx / 4;
                gy = gy / 4;
                res.grad_horizontal = gx[GRAD_W-1:0];
                res.grad_vertical   = gy[GRAD_W-1:0];
                res.center_col      = COORD_W'(col - 1);
                res.center_row      = COORD_W'(row - 1);
                pending_gradients.push_back(res);
            end

            window[0] = window[3];
            window[1] = window[4];
            window[2] = window[5];
            window[3] = up[PIX_W-1:0];
            window[4] = mid[PIX_W-1:0];
            window[5] = gray[PIX_W-1:0];
            window_known[0] = window_known[3];
            window_known[1] = window_known[4];
            window_known[2] = window_known[5];
            window_known[3] = up_ok;
            window_known[4] = mid_ok;
            window_known[5] = 1'b1;

            if (col + 1 >= width) begin
                col_count = 0;
                if (row_count < DEF_MAX_HEIGHT - 1) row_count++;
            end else begin
                col_count = col + 1;
            end
        endfunction

        function void note_error(string msg);
            errors++;
            if (shown < MISMATCH_SHOW_LIMIT) begin
                shown++;
                $display("mismatch: %s", msg);
            end
        endfunction

        function void match_gradient(logic [OUT_DATA_W-1:0] word);
            t_result got;
            t_result want;
            got = word[$bits(t_result)-1:0];
            if (pending_gradients.size() == 0) begin
                note_error($sformatf("unexpected result gx %0d gy %0d col %0d row %0d",
                                     got.grad_horizontal, got.grad_vertical,
                                     got.center_col, got.center_row));
                return;
            end
            want = pending_gradients.pop_front();
            if (got.grad_horizontal !== want.grad_horizontal ||
                got.grad_vertical !== want.grad_vertical ||
                got.center_col !== want.center_col ||
                got.center_row !== want.center_row ||
                word[OUT_DATA_W-1:$bits(t_result)] !== '0) begin
                note_error($sformatf(
                    "expected gx %0d gy %0d col %0d row %0d, got gx %0d gy %0d col %0d row %0d pad %0h",
                    want.grad_horizontal, want.grad_vertical, want.center_col, want.center_row,
                    got.grad_horizontal, got.grad_vertical, got.center_col, got.center_row,
                    word[OUT_DATA_W-1:$bits(t_result)]));
            end
        endfunction
    endclass

endpackage

/* tb/gray_sobel_gradient_test.sv */
// Self-checking testbench for the gray Sobel gradient block.
module gray_sobel_gradient_test;
    import gsg_pkg::*;
    import gsg_check_pkg::*;

    // Watchdog limit, far above the length of the slowest correct run.
    localparam int CYCLE_LIMIT    = 1_000_000;
    // Settling wait after all results have arrived, before reprogramming.
    localparam int SETTLE_CYCLES  = 8;
    // Length of the long receiver hold-off that fills the result queue.
    localparam int RX_HOLD_CYCLES = 400;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]      i_cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // blue [7:0], green [15:8], red [23:16]
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // start_of_frame [0]
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // grad_horizontal [8:0], grad_vertical [17:9], center_col [29:18],
    // center_row [41:30], zero [47:42]
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    sobel_window           board;
    int                    src_idle_pct = 0;
    int                    rx_idle_pct  = 0;
    bit                    rx_hold_req  = 1'b0;
    int                    cycle_count  = 0;
    logic [OUT_DATA_W-1:0] result_word;

    gray_sobel_gradient dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog: a missing result would otherwise hang the drain loops forever.
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver side. Outside a hold-off, tready is drawn each cycle against the
    // current idle percentage. A hold-off request keeps tready low for a long
    // stretch so that the result queue fills and the block stalls its input.
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Result monitor. The handshake is sampled at the falling edge, where all
    // signals are settled, and the transaction is checked at the next rising
    // edge, where it takes place.
    always begin
        @(negedge i_clk);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            result_word = m_axis_tdata;
            @(posedge i_clk);
            board.match_gradient(result_word);
        end
    end

    // Mostly uniform channel values, with the extremes drawn more often.
    function automatic bit [PIX_W-1:0] rand_channel();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    // Offers one pixel after a random number of idle cycles and returns at the
    // rising edge where the transaction completes. Valid stays high when the
    // next pixel follows without a gap.
    task automatic send_pixel(input bit [PIX_W-1:0] blue, green, red, input bit sof);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {red, green, blue};
        s_axis_tuser  <= sof;
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        board.accept_pixel(blue, green, red, sof);
    endtask

    // Stops offering pixels, waits until every predicted result has arrived,
    // then lets the pipeline settle for the given number of cycles.
    task automatic wait_drained(input int settle);
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic program_width(input bit [CFG_W-1:0] value);
        wait_drained(SETTLE_CYCLES);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        board.set_width(value);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Random pixels in long raster runs with occasional frame restarts. A frame
    // start is forced whenever the next window would reach line entries that
    // have never been written, which can happen after the width grows.
    task automatic run_random(input int count, input int sof_per_mille, input bit lead_sof,
                              input int hold_at, input int pause_at);
        bit sof;
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) rx_hold_req = 1'b1;
            if (n == pause_at) wait_drained(0);
            sof = (n == 0 && lead_sof) || ($urandom_range(999) < sof_per_mille);
            sof = sof || board.needs_restart();
            send_pixel(rand_channel(), rand_channel(), rand_channel(), sof);
        end
    endtask

    initial begin
        bit [PIX_W-1:0] row_levels [4];
        bit [PIX_W-1:0] col_levels [5];

        board = new();
        row_levels = '{8'd0, 8'd255, 8'd255, 8'd0};
        col_levels = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd0};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles often, receiver even more.
        src_idle_pct = 37;
        rx_idle_pct  = 62;

        // A width below the minimum acts as three. Flat rows 0, 255, 255, 0 give
        // the largest positive and then the largest negative vertical gradient.
        program_width(0);
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
                send_pixel(row_levels[r], row_levels[r], row_levels[r], r == 0 && c == 0);
            end
        end

        // A bright center column over five columns gives the largest positive,
        // zero, and the largest negative horizontal gradient in one frame.
        program_width(5);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 5; c++) begin
                send_pixel(col_levels[c], col_levels[c], col_levels[c], r == 0 && c == 0);
            end
        end

        program_width(CFG_W'($urandom_range(8, 12)));
        run_random(500, 7, 1'b1, -1, -1);
        // Narrower width while the frame is still running, with no new frame start.
        program_width(CFG_W'($urandom_range(3, 7)));
        run_random(300, 0, 1'b0, -1, -1);

        // Now the receiver is the quicker side.
        src_idle_pct = 62;
        rx_idle_pct  = 37;
        program_width(CFG_W'($urandom_range(0, 2)));
        run_random(400, 10, 1'b1, -1, -1);
        program_width(CFG_W'($urandom_range(13, 64)));
        run_random(400, 10, 1'b0, -1, -1);

        // Full throughput on both sides.
        src_idle_pct = 0;
        rx_idle_pct  = 0;

        // A width above the maximum acts as the maximum. Halfway through the
        // second row the width is rewritten to the maximum itself; the third
        // row then reaches the last interior column.
        program_width('1);
        run_random(DEF_MAX_WIDTH + DEF_MAX_WIDTH / 2, 0, 1'b1, -1, -1);
        program_width(CFG_W'(DEF_MAX_WIDTH));
        run_random(DEF_MAX_WIDTH + DEF_MAX_WIDTH / 2 + 56, 0, 1'b0, -1, -1);

        // Minimum width for enough rows that the row counter saturates and the
        // last rows keep reporting the same center row.
        program_width(CFG_W'(MIN_WIDTH));
        run_random(MIN_WIDTH * (DEF_MAX_HEIGHT + 2), 0, 1'b1, -1, -1);

        // Random width with a long receiver hold-off while pixels keep coming,
        // and a pause in the middle until all pending results have arrived.
        program_width(CFG_W'($urandom_range(3, 40)));
        run_random(500, 5, 1'b1, 150, 350);

        wait_drained(2 * SETTLE_CYCLES);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
